FILE: rtl/core/pst_pkg.sv
package pst_pkg;

    // request codes
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_RUN    = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // fixed field widths
    localparam int PORT_SLOT_W = 10;
    localparam int ID_W        = 32;

    typedef struct packed {
        logic [1:0]             action;
        logic [PORT_SLOT_W-1:0] slot_index;
        logic [ID_W-1:0]        query_id;
        logic [ID_W-1:0]        parent_ident;
        logic                   check_perm;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        logic [PORT_SLOT_W-1:0] result_slot;
        logic [ID_W-1:0]        result_id;
    } rsp_t;

    // one slot memory word
    typedef struct packed {
        logic            in_use;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] parent;
    } slot_entry_t;

endpackage

FILE: rtl/core/pst_req_if.sv
interface pst_req_if;
    import pst_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/pst_rsp_if.sv
interface pst_rsp_if;
    import pst_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/process_slot_table_with_ids.sv
// flow: the request beat is registered together with the slot memory read; the update then
// writes the response register once the output register is free, and response valid rises with it
// one request is in flight at a time: the next is taken only after the read-then-write update
// a new request is taken while the previous response still waits in the output register
// reset: a clearing pass over all 2**SLOT_COUNT_LOG2 slots fills the free stack and clears
// the in-use flags; no request is accepted until it ends
module process_slot_table_with_ids #(
    parameter int SLOT_COUNT_LOG2 = 10
) (
    input  logic  clk,
    input  logic  rst_n,
    pst_req_if.sink   req,
    pst_rsp_if.source rsp
);
    import pst_pkg::*;

    localparam int SW = SLOT_COUNT_LOG2;
    localparam int N  = 1 << SW;
    localparam int CW = ID_W - 1 - SW;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // slot index to port width
    function automatic logic [PORT_SLOT_W-1:0] to_port(input logic [SW-1:0] s);
        logic [SW+PORT_SLOT_W-1:0] e;
        e = {{PORT_SLOT_W{1'b0}}, s};
        return e[PORT_SLOT_W-1:0];
    endfunction

    logic                 state_reg;
    logic                 clearing_reg;
    logic [SW-1:0]        clr_idx_reg;
    logic [SW:0]          fc_reg, fc_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [SW-1:0]        cur_slot_reg, cur_slot_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [ID_W-1:0]      cur_id_reg, cur_id_next;
    req_t                 req_reg;
    rsp_t                 rsp_reg, rsp_next;
    logic                 out_valid_reg;

    slot_entry_t          slot_mem [N];
    logic [SW-1:0]        stack_mem [N];
    slot_entry_t          ent_q;
    logic [SW-1:0]        pop_q;

    logic                 accept;
    logic                 out_free;
    logic                 done;
    logic [SW+PORT_SLOT_W-1:0] rd_ext;
    logic [SW-1:0]        rd_addr;
    logic                 a_we;
    logic [SW-1:0]        a_waddr;
    slot_entry_t          a_wdata;
    logic                 b_we;
    logic [SW-1:0]        b_waddr;
    logic [SW-1:0]        b_wdata;

    logic [SW+PORT_SLOT_W-1:0] s_ext;
    logic                 s_ok;
    logic [SW-1:0]        s_int;
    logic [SW-1:0]        q_slot;
    logic [CW-1:0]        cnt_inc;
    logic [ID_W-1:0]      new_id;

    assign req.ready = !clearing_reg && (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // request slot, range checked against table size
    assign s_ext   = {{SW{1'b0}}, req_reg.slot_index};
    assign s_ok    = s_ext < (SW + PORT_SLOT_W)'(N);
    assign s_int   = s_ext[SW-1:0];
    assign q_slot  = req_reg.query_id[SW-1:0];
    assign cnt_inc = cnt_reg + 1'b1;
    assign new_id  = {cnt_inc, 1'b0, pop_q};

    // read address chosen from the incoming beat
    assign rd_ext = {{SW{1'b0}}, req.payload.slot_index};

    always_comb
    begin
        if (req.payload.action == ACT_LOOKUP)
            rd_addr = req.payload.query_id[SW-1:0];
        else
            rd_addr = rd_ext[SW-1:0];
    end

    // update logic for the executing request, or the clearing pass
    always_comb
    begin
        rsp_next       = '0;
        done           = 1'b0;
        a_we           = 1'b0;
        a_waddr        = s_int;
        a_wdata        = ent_q;
        b_we           = 1'b0;
        b_waddr        = fc_reg[SW-1:0];
        b_wdata        = s_int;
        fc_next        = fc_reg;
        cnt_next       = cnt_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;

        if (clearing_reg)
        begin
            a_we    = 1'b1;
            a_waddr = clr_idx_reg;
            a_wdata = '0;
            b_we    = 1'b1;
            b_waddr = clr_idx_reg;
            b_wdata = ~clr_idx_reg;
        end
        else if (state_reg == S_EXEC && out_free)
        begin
            done            = 1'b1;
            rsp_next.status = ST_BAD;
            case (req_reg.action)
                ACT_ALLOC:
                begin
                    if (fc_reg == '0 || fc_reg > (SW+1)'(N))
                        rsp_next.status = ST_FULL;
                    else
                    begin
                        fc_next   = fc_reg - 1'b1;
                        cnt_next  = cnt_inc;
                        a_we      = 1'b1;
                        a_waddr   = pop_q;
                        a_wdata   = '{in_use: 1'b1, id: new_id,
                                      parent: req_reg.parent_ident};
                        rsp_next  = '{status: ST_OK, found: 1'b1,
                                      result_slot: to_port(pop_q), result_id: new_id};
                    end
                end
                ACT_FREE:
                begin
                    if (s_ok && ent_q.in_use && fc_reg < (SW+1)'(N))
                    begin
                        a_we           = 1'b1;
                        a_wdata.in_use = 1'b0;
                        b_we           = 1'b1;
                        fc_next        = fc_reg + 1'b1;
                        if (cur_valid_reg && cur_slot_reg == s_int)
                            cur_valid_next = 1'b0;
                        rsp_next.status = ST_OK;
                    end
                end
                ACT_LOOKUP:
                begin
                    if (req_reg.query_id == '0)
                    begin
                        rsp_next.status = ST_OK;
                        if (cur_valid_reg)
                        begin
                            rsp_next.found       = 1'b1;
                            rsp_next.result_slot = to_port(cur_slot_reg);
                            rsp_next.result_id   = cur_id_reg;
                        end
                    end
                    else if (ent_q.in_use && ent_q.id == req_reg.query_id &&
                             (!req_reg.check_perm ||
                              (cur_valid_reg && (q_slot == cur_slot_reg ||
                                                 ent_q.parent == cur_id_reg))))
                    begin
                        rsp_next = '{status: ST_OK, found: 1'b1,
                                     result_slot: to_port(q_slot), result_id: ent_q.id};
                    end
                end
                ACT_RUN:
                begin
                    if (s_ok && ent_q.in_use)
                    begin
                        cur_slot_next   = s_int;
                        cur_valid_next  = 1'b1;
                        cur_id_next     = ent_q.id;
                        rsp_next.status = ST_OK;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_BAD;
                end
            endcase
        end
    end

    // slot memory and free stack, registered read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_q <= slot_mem[rd_addr];
            pop_q <= stack_mem[fc_reg[SW-1:0] - 1'b1];
        end
        if (a_we)
            slot_mem[a_waddr] <= a_wdata;
        if (b_we)
            stack_mem[b_waddr] <= b_wdata;
    end

    // request capture and response register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req.payload;
        if (done)
            rsp_reg <= rsp_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            fc_reg        <= (SW+1)'(N);
            cnt_reg       <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                    clearing_reg <= 1'b0;
            end
            if (accept)
                state_reg <= S_EXEC;
            else if (done)
                state_reg <= S_IDLE;
            fc_reg        <= fc_next;
            cnt_reg       <= cnt_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            cur_id_reg    <= cur_id_next;
            if (done)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // checks
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= (SW+1)'(N))
        else $error("free count above table size");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !clearing_reg)
        else $error("request beat during clearing pass");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted request not executing");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.status == ST_FULL) |-> fc_reg == '0)
        else $error("full status with free slots left");

endmodule

FILE: tb/process_slot_table_with_ids_tb.sv
module process_slot_table_with_ids_tb;
    import pst_pkg::*;

    localparam int SLOTS_LOG2  = 10;
    localparam int SLOTS       = 1 << SLOTS_LOG2;
    localparam int ID_SHIFT    = SLOTS_LOG2 + 1;
    localparam int CTR_W       = ID_W - ID_SHIFT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 120;
    localparam int MAX_SHOWN   = 10;

    logic clk;
    logic rst_n;

    pst_req_if req_ch();
    pst_rsp_if rsp_ch();

    process_slot_table_with_ids #(
        .SLOT_COUNT_LOG2(SLOTS_LOG2)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // mirror of the slot table
    logic [PORT_SLOT_W-1:0] free_lifo [SLOTS];
    int                     free_depth;
    bit                     slot_busy [SLOTS];
    logic [ID_W-1:0]        slot_ident [SLOTS];
    logic [ID_W-1:0]        slot_owner [SLOTS];
    logic [PORT_SLOT_W-1:0] run_slot;
    bit                     run_valid;
    logic [CTR_W-1:0]       gen_count;
    int                     live_slots [$];

    // replies owed by the block, oldest first
    rsp_t due_replies [$];

    // traffic shaping
    int send_idle_pct;
    int stall_pct;
    int hold_asked;
    int hold_granted;
    int hold_left;

    // run statistics
    int act_seen [4];
    int perm_lookups;
    int full_hits;
    int replies_checked;
    int mismatches;
    int cycle_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d replies outstanding", due_replies.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            free_lifo[i] = PORT_SLOT_W'(SLOTS - 1 - i);
            slot_busy[i] = 1'b0;
        end
        free_depth = SLOTS;
        run_slot   = '0;
        run_valid  = 1'b0;
        gen_count  = '0;
        live_slots.delete();
    endfunction

    // apply one request to the mirror and return the reply it owes
    function automatic rsp_t apply_request(req_t r);
        rsp_t            o;
        int              s;
        logic [ID_W-1:0] q;
        o = '0;
        o.status = ST_OK;
        case (r.action)
            ACT_ALLOC:
            begin
                if (free_depth == 0)
                    o.status = ST_FULL;
                else
                begin
                    free_depth--;
                    s = free_lifo[free_depth];
                    gen_count++;
                    slot_busy[s]  = 1'b1;
                    slot_owner[s] = r.parent_ident;
                    slot_ident[s] = (ID_W'(gen_count) << ID_SHIFT) | ID_W'(s);
                    live_slots.push_back(s);
                    o.found       = 1'b1;
                    o.result_slot = PORT_SLOT_W'(s);
                    o.result_id   = slot_ident[s];
                end
            end
            ACT_FREE:
            begin
                s = r.slot_index;
                if (s >= SLOTS || !slot_busy[s])
                    o.status = ST_BAD;
                else
                begin
                    slot_busy[s] = 1'b0;
                    free_lifo[free_depth] = PORT_SLOT_W'(s);
                    free_depth++;
                    if (run_valid && run_slot == s)
                        run_valid = 1'b0;
                    for (int i = 0; i < live_slots.size(); i++)
                    begin
                        if (live_slots[i] == s)
                        begin
                            live_slots.delete(i);
                            break;
                        end
                    end
                end
            end
            ACT_LOOKUP:
            begin
                q = r.query_id;
                s = q[SLOTS_LOG2-1:0];
                if (q == '0)
                begin
                    // id zero names the current slot, no checks
                    if (run_valid)
                    begin
                        o.found       = 1'b1;
                        o.result_slot = run_slot;
                        o.result_id   = slot_ident[run_slot];
                    end
                end
                else if (!slot_busy[s] || slot_ident[s] != q)
                    o.status = ST_BAD;
                else if (r.check_perm && !run_valid)
                    o.status = ST_BAD;
                else if (r.check_perm && s != run_slot && slot_owner[s] != slot_ident[run_slot])
                    o.status = ST_BAD;
                else
                begin
                    o.found       = 1'b1;
                    o.result_slot = PORT_SLOT_W'(s);
                    o.result_id   = slot_ident[s];
                end
            end
            default:
            begin
                s = r.slot_index;
                if (s >= SLOTS || !slot_busy[s])
                    o.status = ST_BAD;
                else
                begin
                    run_slot  = PORT_SLOT_W'(s);
                    run_valid = 1'b1;
                end
            end
        endcase
        return o;
    endfunction

    function automatic req_t build_request(logic [1:0] act, int slot, logic [ID_W-1:0] qid,
                                           logic [ID_W-1:0] parent, bit perm);
        req_t r;
        r.action       = act;
        r.slot_index   = PORT_SLOT_W'(slot);
        r.query_id     = qid;
        r.parent_ident = parent;
        r.check_perm   = perm;
        return r;
    endfunction

    // random request, mostly aimed at live slots and their ids
    function automatic req_t make_request(int w_alloc, int w_free, int w_lookup);
        req_t            r;
        int              pick;
        int              roll;
        logic [ID_W-1:0] known;
        r.action       = 2'($urandom);
        r.slot_index   = PORT_SLOT_W'($urandom);
        r.query_id     = $urandom;
        r.parent_ident = $urandom;
        r.check_perm   = 1'($urandom);
        if (live_slots.size() > 0)
            known = slot_ident[live_slots[$urandom_range(live_slots.size() - 1)]];
        else
            known = $urandom;
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        if (pick < w_alloc)
        begin
            r.action = ACT_ALLOC;
            if (roll < 50)
                r.parent_ident = known;
            else if (roll < 70)
                r.parent_ident = '0;
        end
        else if (pick < w_alloc + w_free)
        begin
            r.action = ACT_FREE;
            if (roll < 80)
                r.slot_index = known[SLOTS_LOG2-1:0];
        end
        else if (pick < w_alloc + w_free + w_lookup)
        begin
            r.action = ACT_LOOKUP;
            if (roll < 15)
                r.query_id = '0;
            else if (roll < 70)
                r.query_id = known;
            else if (roll < 82)
                // stale or forged generation bits
                r.query_id = known ^ (ID_W'(1) << $urandom_range(ID_W - 1, ID_SHIFT));
            else if (roll < 90 && run_valid)
                r.query_id = slot_ident[run_slot];
        end
        else
        begin
            r.action = ACT_RUN;
            if (roll < 80)
                r.slot_index = known[SLOTS_LOG2-1:0];
        end
        return r;
    endfunction

    // offer one beat, with random idle cycles in front of it
    task automatic send_request(req_t r);
        logic [95:0] noise;
        rsp_t        owed;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            noise = {$urandom, $urandom, $urandom};
            req_ch.valid   <= 1'b0;
            req_ch.payload <= noise[$bits(req_t)-1:0];
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        owed = apply_request(r);
        due_replies.push_back(owed);
        act_seen[r.action]++;
        if (r.action == ACT_LOOKUP && r.check_perm)
            perm_lookups++;
        if (owed.status == ST_FULL)
            full_hits++;
    endtask

    // receiver ready, with random stalls and an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_granted != hold_asked)
        begin
            hold_left    = HOLD_LEN;
            hold_granted = hold_asked;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void log_fault(string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("reply %0d: %s", replies_checked, what);
    endfunction

    // compare each reply beat with the oldest owed reply
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            replies_checked++;
            got = rsp_ch.payload;
            if (due_replies.size() == 0)
                log_fault($sformatf("unexpected beat status %0d found %0b slot %0d id %h",
                                    got.status, got.found, got.result_slot, got.result_id));
            else
            begin
                want = due_replies.pop_front();
                if (got.status !== want.status || got.found !== want.found
                    || got.result_slot !== want.result_slot
                    || got.result_id !== want.result_id)
                    log_fault($sformatf({"want status %0d found %0b slot %0d id %h, ",
                                         "got status %0d found %0b slot %0d id %h"},
                                        want.status, want.found, want.result_slot,
                                        want.result_id, got.status, got.found,
                                        got.result_slot, got.result_id));
            end
        end
    end

    // empty table: nothing current, nothing in use
    task automatic test_fresh_table();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_request(build_request(ACT_LOOKUP, 0, '0, '0, 1'b0));
        send_request(build_request(ACT_LOOKUP, 0, '0, '0, 1'b1));
        send_request(build_request(ACT_LOOKUP, SLOTS - 1, '1, '1, 1'b1));
        send_request(build_request(ACT_FREE, 3, '0, '0, 1'b0));
        send_request(build_request(ACT_RUN, 0, '0, '0, 1'b0));
    endtask

    // allocation order, ids, parent links and permission checks
    task automatic test_alloc_lookup();
        send_request(build_request(ACT_ALLOC, 0, '0, '0, 1'b0));
        send_request(build_request(ACT_ALLOC, 0, '0, slot_ident[0], 1'b0));
        send_request(build_request(ACT_ALLOC, SLOTS - 1, '1, '1, 1'b1));
        send_request(build_request(ACT_LOOKUP, 0, slot_ident[2], '0, 1'b0));
        // permission check with nothing current
        send_request(build_request(ACT_LOOKUP, 0, slot_ident[1], '0, 1'b1));
        send_request(build_request(ACT_RUN, 0, '0, '0, 1'b0));
        send_request(build_request(ACT_LOOKUP, 0, '0, '0, 1'b0));
        send_request(build_request(ACT_LOOKUP, 0, slot_ident[1], '0, 1'b1));
        send_request(build_request(ACT_LOOKUP, 0, slot_ident[2], '0, 1'b1));
        send_request(build_request(ACT_LOOKUP, 0, slot_ident[0], '0, 1'b1));
        send_request(build_request(ACT_LOOKUP, 0, slot_ident[1] ^ 32'h8000_0000, '0, 1'b0));
    endtask

    // freeing, double free, slot reuse and freeing the current slot
    task automatic test_free_run();
        logic [ID_W-1:0] old_id;
        old_id = slot_ident[1];
        send_request(build_request(ACT_FREE, 1, '0, '0, 1'b0));
        send_request(build_request(ACT_LOOKUP, 0, old_id, '0, 1'b0));
        send_request(build_request(ACT_FREE, 1, '0, '0, 1'b0));
        send_request(build_request(ACT_ALLOC, 0, '0, 32'h1234_5678, 1'b0));
        send_request(build_request(ACT_RUN, SLOTS - 1, '0, '0, 1'b1));
        send_request(build_request(ACT_FREE, SLOTS - 1, '1, '1, 1'b1));
        send_request(build_request(ACT_FREE, 0, '0, '0, 1'b0));
        send_request(build_request(ACT_LOOKUP, 0, '0, '0, 1'b1));
        send_request(build_request(ACT_RUN, 2, '0, '0, 1'b0));
        send_request(build_request(ACT_LOOKUP, 0, '0, '0, 1'b0));
    endtask

    task automatic test_random_mix(int count, int idle_pct, int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count)
            send_request(make_request(35, 20, 30));
    endtask

    // fill the table past full, then free slots again until 16 are free
    task automatic test_fill_and_drain();
        send_idle_pct = 16;
        stall_pct     = 16;
        while (free_depth > 0)
            send_request(make_request(98, 1, 1));
        repeat (3)
            send_request(make_request(100, 0, 0));
        while (live_slots.size() > SLOTS - 16)
            send_request(make_request(5, 75, 15));
    endtask

    // receiver holds off while the sender keeps pushing
    task automatic test_input_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_asked++;
        repeat (30)
            send_request(make_request(40, 15, 30));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_asked     = 0;
        hold_granted   = 0;
        hold_left      = 0;
        clear_table();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_fresh_table();
        test_alloc_lookup();
        test_free_run();
        test_random_mix(30, 0, 0);
        test_random_mix(30, 70, 0);
        test_random_mix(30, 0, 70);
        test_fill_and_drain();
        test_input_backpressure();
        test_random_mix(20, 16, 16);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (due_replies.size() == 0);
        repeat (8) @(posedge clk);

        $display("%0d requests: %0d alloc, %0d free, %0d lookup, %0d run; %0d replies checked",
                 act_seen[ACT_ALLOC] + act_seen[ACT_FREE] + act_seen[ACT_LOOKUP]
                 + act_seen[ACT_RUN], act_seen[ACT_ALLOC], act_seen[ACT_FREE],
                 act_seen[ACT_LOOKUP], act_seen[ACT_RUN], replies_checked);
        $display("table full %0d times, %0d permission lookups, %0d mismatches",
                 full_hits, perm_lookups, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
